### sv/linear_2x2_cramer_solver_top_macros.svh
// assertion macros for the cramer solver
`ifndef LINEAR_2X2_CRAMER_SOLVER_TOP_MACROS_SVH
`define LINEAR_2X2_CRAMER_SOLVER_TOP_MACROS_SVH

// same-cycle implication
`define LCS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define LCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### sv/lcs_pkg.sv
// shared types and helpers for the cramer solver
`timescale 1ns / 1ps
package lcs_pkg;

   localparam int QUO_BITS = 32;
   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_MAX = 32'h8000_0000;

   typedef enum logic [1:0] {
      ST_UNIQUE = 2'd0,
      ST_NONE   = 2'd1,
      ST_MANY   = 2'd2
   } lcs_status_type;

   // one system travelling down the divider chain
   typedef struct packed {
      logic           vld;
      lcs_status_type status;
      logic [31:0]    den;
      logic [31:0]    rem_x;
      logic [31:0]    rem_y;
      logic [31:0]    src_x;
      logic [31:0]    src_y;
      logic [31:0]    quo_x;
      logic [31:0]    quo_y;
      logic           neg_x;
      logic           neg_y;
      logic           big_x;
      logic           big_y;
   } lcs_item_type;

   typedef struct packed {
      logic        sat;
      logic [31:0] val;
   } lcs_lane_type;

   // sign, saturation and truncation toward zero of one quotient
   function automatic lcs_lane_type lcs_finish(logic [31:0] quo, logic big, logic neg);
      lcs_lane_type r;
      r.sat = big | (!neg & quo[31]) | (neg & (quo > NEG_MAX));
      if (r.sat) begin
         r.val = neg ? NEG_MAX : POS_MAX;
      end else begin
         r.val = neg ? 32'(32'd0 - quo) : quo;
      end
      return r;
   endfunction

endpackage

### sv/lcs_front.sv
// products, cramer numerators and the divider set-up
`timescale 1ns / 1ps
module lcs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_vld,
   input  logic signed [15:0]  a1,
   input  logic signed [15:0]  b1,
   input  logic signed [15:0]  c1,
   input  logic signed [15:0]  a2,
   input  logic signed [15:0]  b2,
   input  logic signed [15:0]  c2,
   input  logic [31:0]         tol,
   output lcs_pkg::lcs_item_type item_out
);
   import lcs_pkg::*;

   // stage 0: products
   logic               s0_vld_ff;
   logic signed [31:0] p_ab_ff, p_ba_ff, p_cb_ff, p_cb2_ff, p_ac_ff, p_ca_ff;
   // stage 1: determinant and numerators
   logic               s1_vld_ff;
   logic signed [32:0] det_ff, dnx_ff, dny_ff;
   logic signed [32:0] det_in, dnx_in, dny_in;
   // stage 2: magnitudes and signs
   logic               s2_vld_ff;
   logic [31:0]        mag_d_ff, mag_x_ff, mag_y_ff;
   logic               sgn_d_ff, sgn_x_ff, sgn_y_ff;
   logic [32:0]        abs_d, abs_x, abs_y;
   // stage 3: classification
   lcs_item_type       item_ff, item_in;
   logic               sing;

   assign det_in = 33'(p_ab_ff) - 33'(p_ba_ff);
   assign dnx_in = 33'(p_cb_ff) - 33'(p_cb2_ff);
   assign dny_in = 33'(p_ac_ff) - 33'(p_ca_ff);

   assign abs_d = det_ff[32] ? 33'(-det_ff) : det_ff;
   assign abs_x = dnx_ff[32] ? 33'(-dnx_ff) : dnx_ff;
   assign abs_y = dny_ff[32] ? 33'(-dny_ff) : dny_ff;

   always_comb begin
      sing = mag_d_ff <= tol;
      item_in.vld = s2_vld_ff;
      if (sing) begin
         item_in.status = (mag_x_ff <= tol && mag_y_ff <= tol) ? ST_MANY : ST_NONE;
      end else begin
         item_in.status = ST_UNIQUE;
      end
      item_in.den   = mag_d_ff;
      // quotient of 2^32 or more is known to saturate
      item_in.big_x = {16'd0, mag_x_ff[31:16]} >= mag_d_ff;
      item_in.big_y = {16'd0, mag_y_ff[31:16]} >= mag_d_ff;
      item_in.rem_x = {16'd0, mag_x_ff[31:16]};
      item_in.rem_y = {16'd0, mag_y_ff[31:16]};
      item_in.src_x = {mag_x_ff[15:0], 16'd0};
      item_in.src_y = {mag_y_ff[15:0], 16'd0};
      item_in.quo_x = '0;
      item_in.quo_y = '0;
      item_in.neg_x = sgn_x_ff ^ sgn_d_ff;
      item_in.neg_y = sgn_y_ff ^ sgn_d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff   <= 1'b0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         item_ff.vld <= 1'b0;
      end else if (advance) begin
         s0_vld_ff <= in_vld;
         p_ab_ff   <= a1 * b2;
         p_ba_ff   <= a2 * b1;
         p_cb_ff   <= c1 * b2;
         p_cb2_ff  <= c2 * b1;
         p_ac_ff   <= a1 * c2;
         p_ca_ff   <= c1 * a2;
         s1_vld_ff <= s0_vld_ff;
         det_ff    <= det_in;
         dnx_ff    <= dnx_in;
         dny_ff    <= dny_in;
         s2_vld_ff <= s1_vld_ff;
         mag_d_ff  <= abs_d[31:0];
         mag_x_ff  <= abs_x[31:0];
         mag_y_ff  <= abs_y[31:0];
         sgn_d_ff  <= det_ff[32];
         sgn_x_ff  <= dnx_ff[32];
         sgn_y_ff  <= dny_ff[32];
         item_ff   <= item_in;
      end
   end

   assign item_out = item_ff;

endmodule

### sv/lcs_cell.sv
// one restoring division step for both quotients
`timescale 1ns / 1ps
module lcs_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  lcs_pkg::lcs_item_type prev_item,
   output lcs_pkg::lcs_item_type item_out
);
   import lcs_pkg::*;

   lcs_item_type item_ff, item_in;
   logic [32:0]  try_x, try_y, den_w;
   logic         ge_x, ge_y;

   always_comb begin
      den_w = {1'b0, prev_item.den};
      try_x = {prev_item.rem_x, prev_item.src_x[31]};
      try_y = {prev_item.rem_y, prev_item.src_y[31]};
      ge_x  = try_x >= den_w;
      ge_y  = try_y >= den_w;
      item_in       = prev_item;
      item_in.rem_x = ge_x ? 32'(try_x - den_w) : try_x[31:0];
      item_in.rem_y = ge_y ? 32'(try_y - den_w) : try_y[31:0];
      item_in.src_x = {prev_item.src_x[30:0], 1'b0};
      item_in.src_y = {prev_item.src_y[30:0], 1'b0};
      item_in.quo_x = {prev_item.quo_x[30:0], ge_x};
      item_in.quo_y = {prev_item.quo_y[30:0], ge_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.vld <= 1'b0;
      end else if (advance) begin
         item_ff <= item_in;
      end
   end

   assign item_out = item_ff;

endmodule

### sv/linear_2x2_cramer_solver_top.sv
// 2x2 cramer solver: front end, divider cell chain, result register
//
//   channel | direction | transfer when
//   req_    | in        | req_valid && req_ready
//   rsp_    | out       | rsp_valid && rsp_ready
//   csr_    | in        | csr_valid && csr_ready (always ready)
//
// one system per cycle while the result is not stalled (4 front stages, 32 divider
// cells of one quotient bit each, one result register).
// synchronous reset empties the pipe and sets zero_tolerance to 0.
// a stalled result freezes the whole pipe; req_ready follows that stall.
`timescale 1ns / 1ps
module linear_2x2_cramer_solver_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_coef_a1,
   input  logic signed [15:0] req_coef_b1,
   input  logic signed [15:0] req_rhs_c1,
   input  logic signed [15:0] req_coef_a2,
   input  logic signed [15:0] req_coef_b2,
   input  logic signed [15:0] req_rhs_c2,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_solve_status,
   output logic signed [31:0] rsp_sol_x,
   output logic signed [31:0] rsp_sol_y,
   output logic               rsp_overflow,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [31:0]        csr_zero_tolerance
);
   import lcs_pkg::*;

   `include "linear_2x2_cramer_solver_top_macros.svh"

   logic         advance;
   logic [31:0]  tol_ff;
   lcs_item_type chain [QUO_BITS+1];
   lcs_item_type last;
   lcs_lane_type lane_x, lane_y;

   logic         rsp_valid_ff;
   logic [1:0]   status_ff;
   logic [31:0]  sol_x_ff, sol_y_ff;
   logic         ovf_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_valid) begin
         tol_ff <= csr_zero_tolerance;
      end
   end

   lcs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_vld   (req_valid),
      .a1       (req_coef_a1),
      .b1       (req_coef_b1),
      .c1       (req_rhs_c1),
      .a2       (req_coef_a2),
      .b2       (req_coef_b2),
      .c2       (req_rhs_c2),
      .tol      (tol_ff),
      .item_out (chain[0])
   );

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
      lcs_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .prev_item (chain[i]),
         .item_out  (chain[i+1])
      );
   end

   assign last   = chain[QUO_BITS];
   assign lane_x = lcs_finish(last.quo_x, last.big_x, last.neg_x);
   assign lane_y = lcs_finish(last.quo_y, last.big_y, last.neg_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= last.vld;
         status_ff    <= last.status;
         if (last.status == ST_UNIQUE) begin
            sol_x_ff <= lane_x.val;
            sol_y_ff <= lane_y.val;
            ovf_ff   <= lane_x.sat | lane_y.sat;
         end else begin
            sol_x_ff <= '0;
            sol_y_ff <= '0;
            ovf_ff   <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_solve_status = status_ff;
   assign rsp_sol_x        = sol_x_ff;
   assign rsp_sol_y        = sol_y_ff;
   assign rsp_overflow     = ovf_ff;

   `LCS_ASSERT_IMPLY(a_singular_zero, clock, reset,
      rsp_valid && rsp_solve_status != ST_UNIQUE,
      rsp_sol_x == 0 && rsp_sol_y == 0 && !rsp_overflow)
   `LCS_ASSERT_IMPLY(a_ovf_clamped, clock, reset, rsp_valid && rsp_overflow,
      rsp_sol_x == POS_MAX || rsp_sol_x == NEG_MAX || rsp_sol_y == POS_MAX || rsp_sol_y == NEG_MAX)
   `LCS_ASSERT_NEXT(a_chain_holds, clock, reset, !advance && !reset,
      $stable(last) && $stable(chain[0]))

endmodule
